>>> design/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned PAGES     = 4096;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;

  localparam int unsigned PAGE_W = 12;
  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_W = $clog2(MAP_WORDS);
  localparam int unsigned CNT_W  = 13;
  // word counter also holds the number of whole words
  localparam int unsigned FULL_W = CNT_W - BIT_W;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RESET = CNT_W'(PAGES);

  typedef enum logic [1:0] {
    KIND_ALLOC_LOW   = 2'd0,
    KIND_ALLOC_GIVEN = 2'd1,
    KIND_FREE        = 2'd2,
    KIND_CHECK       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_FREE  = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_RESERVED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [PAGE_W-1:0]  page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  granted_page;
    logic               was_taken;
    status_e            status;
  } rsp_t;

  // lowest clear bit of a map word; only meaningful when one exists
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/bitmap_page_allocator_top.sv
// bitmap page allocator: one bit per page, packed 64 pages to a map word.
// request channel (in_valid_i / in_ready_o / in_req_i): kind and page number.
//   kind 0 grants the lowest free page, 1 takes a named page, 2 frees one,
//   3 reports whether one is taken. every request gives exactly one response.
// response channel (out_valid_o / out_ready_i / out_rsp_o): granted page, the
//   page's old bit and a status (done, no free page, page out of range).
// cfg_we_i / cfg_wdata_i write page_count; write it only while idle.
// sequence: a named-page request goes through read, scan and done; an out-of-range
//   one (or a lowest-free one with no whole word) goes straight to done. a lowest-free
//   request reads one map word per cycle through the single map read port and
//   tests it in the shared find-first-zero unit, visiting at most the whole words
//   below page_count, capped at 4096 pages (64 words at full size); the
//   write-back shares the hit cycle.
// one request is worked on at a time; a new one is accepted once the
//   previous result has moved to the output register, so a request holds the
//   sequencer from accept until its result leaves the done state.
// a stalled receiver holds the response in the output register; a finished
//   result then waits in the sequencer and no new request is taken.
// reset makes every page free and sets page_count to 4096; per-word valid
//   flops make never-written words read as zero, so no clearing pass is run.
module bitmap_page_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bpa_pkg::req_t                   in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bpa_pkg::rsp_t                   out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [bpa_pkg::CNT_W-1:0]       cfg_wdata_i
);
  import bpa_pkg::*;

  state_e               state_q, state_d;
  req_t                 req_q, req_d;
  rsp_t                 res_q, res_d;
  rsp_t                 out_rsp_q, out_rsp_d;
  logic                 out_valid_q, out_valid_d;
  logic [FULL_W-1:0]    w_q, w_d;
  logic [CNT_W-1:0]     page_count_q;

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] mem_valid_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;
  logic [WORD_W-1:0]    raddr;
  logic                 mem_we;
  logic [WORD_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;

  logic [CNT_W-1:0]     limit;
  logic [FULL_W-1:0]    full;
  logic [WORD_BITS-1:0] word;
  logic                 hit;
  logic                 last;
  logic [BIT_W-1:0]     zero_bit;
  logic [BIT_W-1:0]     req_bit;
  logic [WORD_BITS-1:0] req_onehot;
  logic                 in_range;
  logic                 accept;
  logic                 out_free;

  assign limit      = (page_count_q > CNT_W'(PAGES)) ? CNT_W'(PAGES) : page_count_q;
  assign full       = limit[CNT_W-1:BIT_W];
  assign word       = rvalid_q ? rdata_q : '0;
  assign hit        = (~word) != '0;
  assign last       = (w_q + FULL_W'(1)) == full;
  assign zero_bit   = first_zero(word);
  assign req_bit    = req_q.page_number[BIT_W-1:0];
  assign req_onehot = WORD_BITS'(1) << req_bit;
  assign in_range   = {1'b0, in_req_i.page_number} < limit;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.kind == KIND_ALLOC_LOW) begin
            state_d = (full == '0) ? ST_DONE : ST_READ;
          end else begin
            state_d = in_range ? ST_READ : ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (req_q.kind != KIND_ALLOC_LOW || hit || last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    req_d       = req_q;
    res_d       = res_q;
    w_d         = w_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    waddr       = w_q[WORD_W-1:0];
    wdata       = word;
    raddr       = (state_q == ST_READ) ? w_q[WORD_W-1:0]
                                       : WORD_W'(w_q + FULL_W'(1));
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.kind == KIND_ALLOC_LOW) begin
            w_d   = '0;
            res_d = '{granted_page: '0, was_taken: 1'b0, status: STATUS_NO_FREE};
          end else begin
            w_d   = FULL_W'(in_req_i.page_number[PAGE_W-1:BIT_W]);
            res_d = '{granted_page: in_req_i.page_number, was_taken: 1'b0,
                      status: STATUS_RANGE};
          end
        end
      end
      ST_READ: begin
      end
      ST_SCAN: begin
        unique case (req_q.kind)
          KIND_ALLOC_LOW: begin
            if (hit) begin
              mem_we = 1'b1;
              wdata  = word | (WORD_BITS'(1) << zero_bit);
              res_d  = '{granted_page: {w_q[WORD_W-1:0], zero_bit}, was_taken: 1'b0,
                         status: STATUS_DONE};
            end else if (last) begin
              res_d = '{granted_page: '0, was_taken: 1'b0, status: STATUS_NO_FREE};
            end else begin
              w_d = w_q + FULL_W'(1);
            end
          end
          KIND_ALLOC_GIVEN: begin
            mem_we = 1'b1;
            wdata  = word | req_onehot;
          end
          KIND_FREE: begin
            mem_we = 1'b1;
            wdata  = word & ~req_onehot;
          end
          KIND_CHECK: begin
          end
          default: begin
          end
        endcase
        if (req_q.kind != KIND_ALLOC_LOW) begin
          res_d = '{granted_page: req_q.page_number, was_taken: word[req_bit],
                    status: STATUS_DONE};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_rsp_d   = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      page_count_q <= PAGE_COUNT_RESET;
      w_q          <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      w_q         <= w_d;
      if (cfg_we_i) begin
        page_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  // page map: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      rvalid_q <= mem_valid_q[raddr] || (mem_we && waddr == raddr);
      if (mem_we) begin
        mem_valid_q[waddr] <= 1'b1;
      end
    end
  end

  // the map is only written while a request is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_SCAN)
    else $error("map write outside scan");

  // the lowest-free scan never passes the last whole word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && req_q.kind == KIND_ALLOC_LOW) |-> w_q < full)
    else $error("scan beyond page limit");

  // an accepted request leaves idle right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ || state_q == ST_DONE))
    else $error("request accepted but not started");

  // failed requests report a clear page bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.status != STATUS_DONE) |-> !out_rsp_q.was_taken)
    else $error("failed request reports taken page");

  // no-free-page result carries page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.status == STATUS_NO_FREE) |-> out_rsp_q.granted_page == '0)
    else $error("no-free result with nonzero page");

endmodule
